### design/cdq_pkg.sv
package cdq_pkg;

	// Ring capacity; must be a power of two.
	localparam int DEPTH = 64;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Field widths of the stream payloads.
	localparam int CMD_W     = 2;
	localparam int VALUE_W   = 32;
	localparam int STATUS_W  = 2;
	localparam int ENTRY_W   = 7;
	localparam int S_TDATA_W = ((VALUE_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((VALUE_W + ENTRY_W + 7) / 8) * 8;
	localparam int M_PAD_W   = M_TDATA_W - VALUE_W - ENTRY_W;

	typedef enum logic [CMD_W-1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_REAR  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_REAR   = 2'd3
	} cdq_op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} cdq_status_t;

	typedef enum logic {
		CDQ_IDLE,
		CDQ_EXEC
	} cdq_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic load_out;
	} cdq_cmd_t;

endpackage

### design/cdq_ram.sv
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/cdq_ctrl.sv
module cdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output cdq_pkg::cdq_cmd_t cmd
);

	import cdq_pkg::*;

	cdq_state_t state_q;
	cdq_state_t state_d;
	logic       m_tvalid_q;
	logic       m_tvalid_d;

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= CDQ_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			m_tvalid_q <= m_tvalid_d;
		end
	end

	// Next state: an accepted item moves to EXEC, where the read data is
	// captured into the output register as soon as that register is free.
	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		cmd.accept   = 1'b0;
		cmd.load_out = 1'b0;
		m_tvalid_d   = m_tvalid_q && !m_tready;
		unique case (state_q)
			CDQ_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
				if (s_tvalid) begin
					state_d = CDQ_EXEC;
				end
			end
			CDQ_EXEC: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.load_out = 1'b1;
					m_tvalid_d   = 1'b1;
					state_d      = CDQ_IDLE;
				end
			end
			default: begin
				state_d = CDQ_IDLE;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;

	// A new result only appears after an item went through EXEC.
	a_rise_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == CDQ_EXEC))
		else $error("output valid rose outside EXEC");

endmodule

### design/cdq_dp.sv
module cdq_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cdq_pkg::cdq_cmd_t                cmd,
	input  logic [cdq_pkg::CMD_W-1:0]        s_tuser,
	input  logic [cdq_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic [cdq_pkg::STATUS_W-1:0]     m_tuser,
	output logic [cdq_pkg::M_TDATA_W-1:0]    m_tdata
);

	import cdq_pkg::*;

	logic        [PTR_W-1:0]   front_q, rear_q;
	logic        [CNT_W-1:0]   count_q;
	logic        [PTR_W-1:0]   front_d, rear_d;
	logic        [CNT_W-1:0]   count_d;
	cdq_op_t                   op;
	logic signed [VALUE_W-1:0] value;
	logic                      full, empty;
	cdq_status_t               status_d;
	logic                      pop_ok_d;
	logic                      we_d, re_d;
	logic        [PTR_W-1:0]   waddr, raddr;
	logic signed [VALUE_W-1:0] rdata;

	cdq_status_t               status_s1;
	logic                      pop_ok_s1;
	logic        [CNT_W-1:0]   count_s1;

	cdq_status_t               out_status_q;
	logic signed [VALUE_W-1:0] out_popped_q;
	logic        [ENTRY_W-1:0] out_count_q;

	assign op    = cdq_op_t'(s_tuser);
	assign value = s_tdata[VALUE_W-1:0];
	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	// Pointer, count and status update for the offered operation.
	always_comb begin
		front_d  = front_q;
		rear_d   = rear_q;
		count_d  = count_q;
		status_d = ST_DONE;
		pop_ok_d = 1'b0;
		we_d     = 1'b0;
		re_d     = 1'b0;
		waddr    = '0;
		raddr    = front_q;
		unique case (op)
			OP_PUSH_FRONT, OP_PUSH_REAR: begin
				if (full) begin
					status_d = ST_FULL;
				end else if (empty) begin
					// The first entry always lands in slot zero.
					front_d = '0;
					rear_d  = '0;
					count_d = CNT_W'(1);
					we_d    = 1'b1;
				end else if (op == OP_PUSH_FRONT) begin
					front_d = front_q - PTR_W'(1);
					waddr   = front_q - PTR_W'(1);
					count_d = count_q + CNT_W'(1);
					we_d    = 1'b1;
				end else begin
					rear_d  = rear_q + PTR_W'(1);
					waddr   = rear_q + PTR_W'(1);
					count_d = count_q + CNT_W'(1);
					we_d    = 1'b1;
				end
			end
			OP_POP_FRONT, OP_POP_REAR: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					re_d     = 1'b1;
					pop_ok_d = 1'b1;
					count_d  = count_q - CNT_W'(1);
					if (op == OP_POP_FRONT) begin
						raddr   = front_q;
						front_d = front_q + PTR_W'(1);
					end else begin
						raddr  = rear_q;
						rear_d = rear_q - PTR_W'(1);
					end
					// Removing the last entry returns both pointers to zero.
					if (count_q == CNT_W'(1)) begin
						front_d = '0;
						rear_d  = '0;
					end
				end
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	cdq_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.accept && we_d),
		.waddr (waddr),
		.wdata (value),
		.re    (cmd.accept && re_d),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Queue state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			rear_q  <= '0;
			count_q <= '0;
		end else if (cmd.accept) begin
			front_q <= front_d;
			rear_q  <= rear_d;
			count_q <= count_d;
		end
	end

	// Result fields held while the read data comes out of the RAM.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			status_s1 <= status_d;
			pop_ok_s1 <= pop_ok_d;
			count_s1  <= count_d;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= status_s1;
			out_popped_q <= pop_ok_s1 ? rdata : '0;
			out_count_q  <= ENTRY_W'(count_s1);
		end
	end

	assign m_tuser = out_status_q;
	assign m_tdata = {{M_PAD_W{1'b0}}, out_count_q, out_popped_q};

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above capacity");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> (front_q == '0 && rear_q == '0))
		else $error("pointers not at zero while empty");

	a_ptr_span: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 |-> (rear_q - front_q + PTR_W'(1)) == count_q[PTR_W-1:0])
		else $error("pointer span disagrees with entry count");

endmodule

### design/circular_deque_top.sv
// Double-ended queue of 32-bit signed values in a ring RAM of DEPTH entries
// (cdq_pkg::DEPTH, a power of two). Each input transfer carries a command in
// s_tuser (push front, push rear, pop front, pop rear) and the value to push in
// s_tdata; each command gives exactly one output transfer with a status in
// m_tuser (done, full, empty) and the popped value and entry count after the
// operation in m_tdata. A push to a full queue and a pop from an empty one are
// rejected and leave the queue unchanged. Each item first passes IDLE, where the
// pointers are updated and the RAM is written or addressed, and then EXEC, where
// the RAM's registered read data is captured into the output register once that
// register is free; a new command is only taken after that capture. The input
// side is taken even while a finished result still waits on m_tready. The RAM
// needs no clearing after reset; only written entries are ever read back.
module circular_deque_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [cdq_pkg::S_TDATA_W-1:0] s_tdata,  // value[31:0]
	input  logic [cdq_pkg::CMD_W-1:0]     s_tuser,  // cmd[1:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [cdq_pkg::M_TDATA_W-1:0] m_tdata,  // popped_value[31:0], entry_count[38:32], zero pad
	output logic [cdq_pkg::STATUS_W-1:0]  m_tuser   // status[1:0]
);

	import cdq_pkg::*;

	cdq_cmd_t cmd;

	// Handshake and sequencing.
	cdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// Pointers, count, ring RAM and output register.
	cdq_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.s_tuser (s_tuser),
		.s_tdata (s_tdata),
		.m_tuser (m_tuser),
		.m_tdata (m_tdata)
	);

endmodule

### tb/tb_circular_deque_top.sv
module tb_circular_deque_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cdq_pkg::*;

	// One command waiting to be sent, with its lead-in gap.
	typedef struct {
		cdq_op_t          op;
		logic [VALUE_W-1:0] value;
		int               gap;
		bit               drain;
	} deque_req_t;

	// One result as the deque should report it.
	typedef struct {
		cdq_status_t        status;
		logic [VALUE_W-1:0] popped;
		logic [ENTRY_W-1:0] count;
	} deque_reply_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [CMD_W-1:0]     s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]  m_tuser;

	deque_req_t   ops_to_send[$];
	deque_reply_t replies_due[$];
	int           errors = 0;

	// Predicted deque contents.
	logic [VALUE_W-1:0] shadow_ring[DEPTH];
	logic [PTR_W-1:0]   shadow_front = '0;
	logic [PTR_W-1:0]   shadow_rear = '0;
	logic [CNT_W-1:0]   shadow_held = '0;

	// Driver state.
	bit         have_cur = 1'b0;
	deque_req_t cur;
	int         hold_left = 0;

	// Receiver state.
	int stall_left = 0;
	int results_seen = 0;
	bit rx_calm = 1'b0;

	circular_deque_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Applies one command to the shadow deque and returns the expected result.
	function automatic deque_reply_t apply_deque_op(cdq_op_t op, logic [VALUE_W-1:0] value);
		deque_reply_t r;
		r.status = ST_DONE;
		r.popped = '0;
		if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
			if (shadow_held == CNT_W'(DEPTH)) begin
				r.status = ST_FULL;
			end else if (shadow_held == '0) begin
				// The first entry always lands in slot zero.
				shadow_front = '0;
				shadow_rear = '0;
				shadow_ring[0] = value;
				shadow_held = CNT_W'(1);
			end else if (op == OP_PUSH_FRONT) begin
				shadow_front = shadow_front - PTR_W'(1);
				shadow_ring[shadow_front] = value;
				shadow_held = shadow_held + CNT_W'(1);
			end else begin
				shadow_rear = shadow_rear + PTR_W'(1);
				shadow_ring[shadow_rear] = value;
				shadow_held = shadow_held + CNT_W'(1);
			end
		end else begin
			if (shadow_held == '0) begin
				r.status = ST_EMPTY;
			end else begin
				if (op == OP_POP_FRONT) begin
					r.popped = shadow_ring[shadow_front];
					shadow_front = shadow_front + PTR_W'(1);
				end else begin
					r.popped = shadow_ring[shadow_rear];
					shadow_rear = shadow_rear - PTR_W'(1);
				end
				shadow_held = shadow_held - CNT_W'(1);
				// Taking the last entry sends both pointers home.
				if (shadow_held == '0) begin
					shadow_front = '0;
					shadow_rear = '0;
				end
			end
		end
		r.count = ENTRY_W'(shadow_held);
		return r;
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_op(cdq_op_t op, logic [VALUE_W-1:0] value, int gap, bit drain);
		deque_req_t r;
		r.op = op;
		r.value = value;
		r.gap = gap;
		r.drain = drain;
		ops_to_send.push_back(r);
	endtask

	// Sender: presents queued commands and predicts each accepted transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready)
				replies_due.push_back(apply_deque_op(cdq_op_t'(s_tuser), s_tdata[VALUE_W-1:0]));
			if (!s_tvalid || s_tready) begin
				if (!have_cur && ops_to_send.size() != 0 &&
				    !(ops_to_send[0].drain && replies_due.size() != 0)) begin
					cur = ops_to_send.pop_front();
					have_cur = 1'b1;
					hold_left = cur.gap;
				end
				if (have_cur && hold_left == 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= S_TDATA_W'(cur.value);
					s_tuser <= cur.op;
					have_cur = 1'b0;
				end else begin
					if (have_cur)
						hold_left--;
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks every result transfer and stalls at random.
	always @(posedge clk or negedge arst_n) begin
		deque_reply_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (replies_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, status %0d data %h", $time, m_tuser, m_tdata);
				end else begin
					want = replies_due.pop_front();
					if (m_tuser !== want.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
					end
					if (m_tdata[VALUE_W-1:0] !== want.popped) begin
						errors++;
						$display("%0t: popped value expected %h actual %h", $time, want.popped,
							m_tdata[VALUE_W-1:0]);
					end
					if (m_tdata[VALUE_W +: ENTRY_W] !== want.count) begin
						errors++;
						$display("%0t: entry count expected %0d actual %0d", $time, want.count,
							m_tdata[VALUE_W +: ENTRY_W]);
					end
				end
				results_seen++;
				if (results_seen % 64 == 0)
					rx_calm = ($urandom_range(0, 2) == 0);
				stall_left = rx_calm ? 0 : $urandom_range(0, 10);
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Stimulus, then wait for the last result.
	initial begin
		int total;
		int len;
		int kind;
		int push_pct;
		bit calm;
		bit drain;
		cdq_op_t op;

		// Directed: pops from empty, extremes, last-entry pops, pop after reset of pointers.
		add_op(OP_POP_FRONT, 32'h1234_5678, 0, 1'b0);
		add_op(OP_POP_REAR, '1, 0, 1'b0);
		add_op(OP_PUSH_FRONT, 32'h8000_0000, 0, 1'b0);
		add_op(OP_POP_REAR, '0, 0, 1'b0);
		add_op(OP_PUSH_REAR, 32'h7fff_ffff, 1, 1'b0);
		add_op(OP_PUSH_FRONT, '1, 0, 1'b0);
		add_op(OP_PUSH_REAR, '0, 0, 1'b0);
		add_op(OP_PUSH_FRONT, 32'h5555_5555, 0, 1'b0);
		add_op(OP_PUSH_REAR, 32'haaaa_aaaa, 2, 1'b0);
		add_op(OP_POP_FRONT, '0, 0, 1'b0);
		add_op(OP_POP_REAR, '0, 0, 1'b0);
		add_op(OP_POP_FRONT, '0, 0, 1'b0);
		add_op(OP_POP_REAR, '0, 0, 1'b0);
		add_op(OP_POP_FRONT, '0, 0, 1'b0);
		add_op(OP_POP_FRONT, '0, 3, 1'b0);
		add_op(OP_PUSH_REAR, 32'h0000_0001, 0, 1'b0);
		add_op(OP_POP_FRONT, '0, 0, 1'b0);
		add_op(OP_POP_REAR, '0, 0, 1'b0);

		// Random segments that swing the fill level between empty and full.
		total = 0;
		while (total < 1800) begin
			len = $urandom_range(20, 120);
			kind = $urandom_range(0, 3);
			case (kind)
				0: push_pct = 90;
				1: push_pct = 15;
				2: push_pct = 50;
				default: push_pct = 100;
			endcase
			calm = ($urandom_range(0, 3) == 0);
			drain = (total == 0) || ($urandom_range(0, 5) == 0);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(1, 100) <= push_pct)
					op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
				else
					op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
				add_op(op, pick_value(), calm ? 0 : $urandom_range(0, 10), drain && i == 0);
			end
			total += len;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (ops_to_send.size() != 0 || have_cur || s_tvalid)
			@(posedge clk);
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog.
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### circular_deque_top.f
design/cdq_pkg.sv
design/cdq_ram.sv
design/cdq_ctrl.sv
design/cdq_dp.sv
design/circular_deque_top.sv
tb/tb_circular_deque_top.sv
